[sv/flpq_pkg.sv]
// ----------------------------------------------------------------------------
// flpq_pkg
// Shared types and constants of the five-level priority queue.
// ----------------------------------------------------------------------------
package flpq_pkg;

    // field widths fixed by the request and result formats
    localparam int ID_W       = 16;
    localparam int LEVEL_W    = 3;
    localparam int STATUS_W   = 3;
    localparam int OCC_W      = 8;
    localparam int NUM_LEVELS = 5;
    localparam int LIDX_W     = 3;

    localparam logic [LEVEL_W-1:0] LEVEL_MIN = 3'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 3'd5;

    // request kind carried on s_axis_tuser
    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_SERVE  = 1'b1
    } action_t;

    // result status carried on m_axis_tuser
    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_SERVED   = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_FULL     = 3'd3,
        ST_BADLEVEL = 3'd4
    } status_t;

    // request sequencer
    typedef enum logic {
        S_IDLE = 1'b0,
        S_BUSY = 1'b1
    } state_t;

endpackage

[sv/flpq_ram.sv]
// ----------------------------------------------------------------------------
// flpq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module flpq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/five_level_priority_queue.sv]
// ----------------------------------------------------------------------------
// five_level_priority_queue
// Bounded priority queue with five urgency levels, FIFO order within a level.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata (low bit up)                              | tuser
//  ---------+-----+-------------------------------------------------+-------------
//  s_axis   | in  | entry_id[15:0], level[18:16], zero pad to 24    | action[0]
//  m_axis   | out | served_id[15:0], served_level[18:16],           | status[2:0]
//           |     | occupancy[26:19], zero pad to 32                |
//
//  Each request is handled in S_IDLE, which issues the node memory reads, then
//  in S_BUSY, which takes the registered read data and does the list write-back.
//  Entries live as per-level linked lists in two RAMs (id and next pointer);
//  unused nodes come from a fill counter, released nodes from a free list.
//  Reset clears only the counters, the state and the output valid flag; no
//  clearing pass is needed. A request is taken only when the output register
//  is empty or is read in the same cycle; while m_axis stalls with a result
//  waiting, s_axis_tready stays low.
//
module five_level_priority_queue
    import flpq_pkg::*;
#(
    parameter int CAPACITY = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // entry_id, level
    input  logic [0:0]  s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // served_id, served_level, occupancy
    output logic [2:0]  m_axis_tuser    // status
);

    localparam int PW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    // request fields
    logic [ID_W-1:0]    in_id;
    logic [LEVEL_W-1:0] in_level;
    action_t            in_action;
    logic               accept;

    assign in_id     = s_axis_tdata[ID_W-1:0];
    assign in_level  = s_axis_tdata[ID_W+LEVEL_W-1:ID_W];
    assign in_action = action_t'(s_axis_tuser[0]);

    // control state
    state_t            state_reg, state_next;
    logic [CW-1:0]     cnt_reg [NUM_LEVELS];
    logic [CW-1:0]     cnt_next [NUM_LEVELS];
    logic [CW-1:0]     total_reg, total_next;
    logic [CW-1:0]     fresh_reg, fresh_next;
    logic              m_valid_reg, m_valid_next;

    // payload state
    logic [PW-1:0]     head_reg [NUM_LEVELS];
    logic [PW-1:0]     head_next [NUM_LEVELS];
    logic [PW-1:0]     tail_reg [NUM_LEVELS];
    logic [PW-1:0]     tail_next [NUM_LEVELS];
    logic [PW-1:0]     free_head_reg, free_head_next;
    status_t           kind_reg, kind_next;
    logic [LIDX_W-1:0] lidx_reg, lidx_next;
    logic [PW-1:0]     node_reg, node_next;
    logic              from_list_reg, from_list_next;
    status_t           m_status_reg, m_status_next;
    logic [ID_W-1:0]   m_id_reg, m_id_next;
    logic [LEVEL_W-1:0] m_level_reg, m_level_next;
    logic [OCC_W-1:0]  m_occ_reg, m_occ_next;

    // memory ports
    logic              id_we;
    logic [PW-1:0]     id_waddr, id_raddr;
    logic [ID_W-1:0]   id_wdata, id_rdata;
    logic              nx_we;
    logic [PW-1:0]     nx_waddr, nx_raddr, nx_wdata, nx_rdata;

    // working values
    logic [LIDX_W-1:0] ins_idx;
    logic [LIDX_W-1:0] top_idx;
    logic              bad_level;
    logic [PW-1:0]     new_node;

    flpq_ram #(.WIDTH(ID_W), .DEPTH(CAPACITY)) u_id_ram (
        .aclk  (aclk),
        .we    (id_we),
        .waddr (id_waddr),
        .wdata (id_wdata),
        .raddr (id_raddr),
        .rdata (id_rdata)
    );

    flpq_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_next_ram (
        .aclk  (aclk),
        .we    (nx_we),
        .waddr (nx_waddr),
        .wdata (nx_wdata),
        .raddr (nx_raddr),
        .rdata (nx_rdata)
    );

    // handshake
    assign s_axis_tready = (state_reg == S_IDLE) && (!m_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // most urgent non-empty level
    always_comb begin
        top_idx = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
            if (cnt_reg[i] != '0) begin
                top_idx = LIDX_W'(i);
            end
        end
    end

    assign ins_idx   = in_level - LEVEL_MIN;
    assign bad_level = (in_level < LEVEL_MIN) || (in_level > LEVEL_MAX);
    assign new_node  = (fresh_reg < CAP_C) ? fresh_reg[PW-1:0] : free_head_reg;

    // sequencer, list update and result
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        total_next     = total_reg;
        fresh_next     = fresh_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        free_head_next = free_head_reg;
        kind_next      = kind_reg;
        lidx_next      = lidx_reg;
        node_next      = node_reg;
        from_list_next = from_list_reg;
        m_valid_next   = m_valid_reg;
        m_status_next  = m_status_reg;
        m_id_next      = m_id_reg;
        m_level_next   = m_level_reg;
        m_occ_next     = m_occ_reg;
        id_we          = 1'b0;
        id_waddr       = new_node;
        id_wdata       = in_id;
        id_raddr       = head_reg[top_idx];
        nx_we          = 1'b0;
        nx_waddr       = tail_reg[ins_idx];
        nx_wdata       = new_node;
        nx_raddr       = free_head_reg;

        // result taken downstream
        if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next     = S_BUSY;
                    from_list_next = 1'b0;
                    if (in_action == ACT_INSERT) begin
                        lidx_next = ins_idx;
                        if (bad_level) begin
                            kind_next = ST_BADLEVEL;
                        end else if (total_reg == CAP_C) begin
                            kind_next = ST_FULL;
                        end else begin
                            // link a new node at the tail of its level
                            kind_next      = ST_INSERTED;
                            node_next      = new_node;
                            id_we          = 1'b1;
                            if (fresh_reg < CAP_C) begin
                                fresh_next = fresh_reg + 1'b1;
                            end else begin
                                from_list_next = 1'b1;
                            end
                            if (cnt_reg[ins_idx] != '0) begin
                                nx_we = 1'b1;
                            end else begin
                                head_next[ins_idx] = new_node;
                            end
                            tail_next[ins_idx] = new_node;
                            cnt_next[ins_idx]  = cnt_reg[ins_idx] + 1'b1;
                            total_next         = total_reg + 1'b1;
                        end
                    end else begin
                        lidx_next = top_idx;
                        if (total_reg == '0) begin
                            kind_next = ST_EMPTY;
                        end else begin
                            // unlink the head of the most urgent level
                            kind_next         = ST_SERVED;
                            node_next         = head_reg[top_idx];
                            nx_raddr          = head_reg[top_idx];
                            cnt_next[top_idx] = cnt_reg[top_idx] - 1'b1;
                            total_next        = total_reg - 1'b1;
                        end
                    end
                end
            end
            S_BUSY: begin
                state_next    = S_IDLE;
                m_valid_next  = 1'b1;
                m_status_next = kind_reg;
                m_id_next     = '0;
                m_level_next  = '0;
                m_occ_next    = OCC_W'(total_reg);
                if (kind_reg == ST_INSERTED && from_list_reg) begin
                    free_head_next = nx_rdata;
                end
                if (kind_reg == ST_SERVED) begin
                    m_id_next          = id_rdata;
                    m_level_next       = lidx_reg + LEVEL_MIN;
                    head_next[lidx_reg] = nx_rdata;
                    // released node goes on the free list
                    nx_we          = 1'b1;
                    nx_waddr       = node_reg;
                    nx_wdata       = free_head_reg;
                    free_head_next = node_reg;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            total_reg   <= '0;
            fresh_reg   <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_LEVELS; i++) begin
                cnt_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            fresh_reg   <= fresh_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        head_reg      <= head_next;
        tail_reg      <= tail_next;
        free_head_reg <= free_head_next;
        kind_reg      <= kind_next;
        lidx_reg      <= lidx_next;
        node_reg      <= node_next;
        from_list_reg <= from_list_next;
        m_status_reg  <= m_status_next;
        m_id_reg      <= m_id_next;
        m_level_reg   <= m_level_next;
        m_occ_reg     <= m_occ_next;
    end

    // result channel
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tdata  = {5'd0, m_occ_reg, m_level_reg, m_id_reg};

endmodule

[bench/five_level_priority_queue_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// five_level_priority_queue_test
// Streams insert and serve requests into the queue with random gaps on both
// channels and checks every result against a sorted-array model of the queue.
// ----------------------------------------------------------------------------
module five_level_priority_queue_test;
    import flpq_pkg::*;

    localparam int CAP         = 128;
    localparam int CYCLE_LIMIT = 200000;
    localparam int QUIET_TAIL  = 150;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_LEN    = 80;
    localparam int DRAIN_WAIT  = 10;
    localparam int ITEM_TARGET = 1150;

    typedef struct packed {
        action_t            act;
        logic [ID_W-1:0]    id;
        logic [LEVEL_W-1:0] lvl;
    } request_t;

    typedef struct packed {
        status_t            st;
        logic [ID_W-1:0]    id;
        logic [LEVEL_W-1:0] lvl;
        logic [OCC_W-1:0]   occ;
    } result_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;   // entry_id, level
    logic [0:0]  s_axis_tuser  = '0;   // action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // served_id, served_level, occupancy
    logic [2:0]  m_axis_tuser;         // status

    // queue contents as the model sees them
    logic [ID_W-1:0]    queue_id  [CAP];
    logic [LEVEL_W-1:0] queue_lvl [CAP];
    int                 queue_count = 0;

    request_t pending_requests[$];
    result_t  expected_results[$];

    int  request_total = 0;
    int  accepted      = 0;
    int  mismatches    = 0;
    int  cycles        = 0;
    bit  request_took  = 1'b0;
    int  tx_gap        = 0;
    int  rx_gap        = 0;
    int  hold_left     = 0;
    bit  hold_done     = 1'b0;

    five_level_priority_queue #(
        .CAPACITY(CAP)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock and reset
    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
    end

    // apply one request to the model queue and return its result
    function automatic result_t queue_apply(request_t r);
        result_t res;
        int      pos;
        res = '{st: ST_INSERTED, id: '0, lvl: '0, occ: '0};
        if (r.act == ACT_INSERT) begin
            if (r.lvl < LEVEL_MIN || r.lvl > LEVEL_MAX) begin
                res.st = ST_BADLEVEL;
            end else if (queue_count >= CAP) begin
                res.st = ST_FULL;
            end else begin
                // behind every entry of the same or a more urgent level
                pos = 0;
                while (pos < queue_count && queue_lvl[pos] <= r.lvl) pos++;
                for (int i = queue_count; i > pos; i--) begin
                    queue_id[i]  = queue_id[i-1];
                    queue_lvl[i] = queue_lvl[i-1];
                end
                queue_id[pos]  = r.id;
                queue_lvl[pos] = r.lvl;
                queue_count++;
                res.st = ST_INSERTED;
            end
        end else if (queue_count == 0) begin
            res.st = ST_EMPTY;
        end else begin
            res.st  = ST_SERVED;
            res.id  = queue_id[0];
            res.lvl = queue_lvl[0];
            for (int i = 1; i < queue_count; i++) begin
                queue_id[i-1]  = queue_id[i];
                queue_lvl[i-1] = queue_lvl[i];
            end
            queue_count--;
        end
        res.occ = queue_count[OCC_W-1:0];
        return res;
    endfunction

    function automatic request_t make_insert(logic [ID_W-1:0] id, logic [LEVEL_W-1:0] lvl);
        request_t r;
        r.act = ACT_INSERT;
        r.id  = id;
        r.lvl = lvl;
        return r;
    endfunction

    // serve requests carry random junk in the ignored fields
    function automatic request_t make_serve();
        request_t r;
        r.act = ACT_SERVE;
        r.id  = ID_W'($urandom);
        r.lvl = LEVEL_W'($urandom);
        return r;
    endfunction

    function automatic logic [LEVEL_W-1:0] random_level();
        int pick;
        pick = $urandom_range(0, 2);
        if ($urandom_range(0, 9) != 0)
            return LEVEL_W'($urandom_range(LEVEL_MIN, LEVEL_MAX));
        else
            return (pick == 0) ? 3'd0 : LEVEL_W'(pick + 5);
    endfunction

    // stimulus and end of run
    initial begin
        int seg_len;
        int insert_pct;
        bit first_seg;

        // directed: empty serve, bad levels, every level, FIFO ties, drain
        pending_requests.push_back(make_serve());
        pending_requests.push_back(make_insert(16'h1234, 3'd0));
        pending_requests.push_back(make_insert(16'hFFFF, 3'd6));
        pending_requests.push_back(make_insert(16'h0000, 3'd7));
        pending_requests.push_back(make_insert(16'hFFFF, LEVEL_MAX));
        pending_requests.push_back(make_insert(16'h0000, LEVEL_MIN));
        pending_requests.push_back(make_insert(16'hA5A5, 3'd3));
        pending_requests.push_back(make_insert(16'h5A5A, 3'd3));
        pending_requests.push_back(make_insert(16'h00FF, 3'd2));
        pending_requests.push_back(make_insert(16'hFF00, 3'd4));
        pending_requests.push_back(make_insert(16'h8001, LEVEL_MAX));
        pending_requests.push_back(make_insert(16'h7FFE, LEVEL_MIN));
        pending_requests.push_back(make_insert(16'hBEEF, 3'd7));
        repeat (9) pending_requests.push_back(make_serve());

        // random: segments that lean toward filling, mixing or draining
        first_seg = 1'b1;
        while (pending_requests.size() < ITEM_TARGET) begin
            if (first_seg) begin
                seg_len    = 250;
                insert_pct = 90;
                first_seg  = 1'b0;
            end else begin
                seg_len = $urandom_range(60, 250);
                case ($urandom_range(0, 2))
                    0: insert_pct = 90;
                    1: insert_pct = 50;
                    default: insert_pct = 15;
                endcase
            end
            // last segment stops at the target count
            if (seg_len > ITEM_TARGET - pending_requests.size())
                seg_len = ITEM_TARGET - pending_requests.size();
            repeat (seg_len) begin
                if ($urandom_range(0, 99) < insert_pct)
                    pending_requests.push_back(make_insert(ID_W'($urandom), random_level()));
                else
                    pending_requests.push_back(make_serve());
            end
        end
        request_total = pending_requests.size();

        wait (aresetn && pending_requests.size() == 0 && accepted == request_total);
        wait (expected_results.size() == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // request driver
    always @(negedge aclk) begin
        if (aresetn && (!s_axis_tvalid || request_took)) begin
            request_took = 1'b0;
            if (tx_gap > 0) begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (accepted < request_total - QUIET_TAIL && $urandom_range(0, 9) == 0) begin
                tx_gap = $urandom_range(0, 2);
                s_axis_tvalid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
                request_t r;
                r = pending_requests.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {5'b0, r.lvl, r.id};
                s_axis_tuser  <= r.act;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result receiver: random stalls plus one long hold-off that back-pressures s_axis
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!hold_done && accepted >= HOLD_AT) begin
                hold_left = HOLD_LEN;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_axis_tready <= 1'b0;
            end else if (accepted < request_total - QUIET_TAIL && $urandom_range(0, 9) == 0) begin
                rx_gap = $urandom_range(0, 2);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // monitor: predict on accepted requests, then check accepted results
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                request_t r;
                r.act = action_t'(s_axis_tuser[0]);
                r.id  = s_axis_tdata[15:0];
                r.lvl = s_axis_tdata[18:16];
                expected_results.push_back(queue_apply(r));
                request_took = 1'b1;
                accepted++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: st=%0d id=%h lvl=%0d occ=%0d",
                                 m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[18:16],
                                 m_axis_tdata[26:19]);
                end else begin
                    result_t e;
                    e = expected_results.pop_front();
                    if (m_axis_tuser !== e.st || m_axis_tdata[15:0] !== e.id ||
                        m_axis_tdata[18:16] !== e.lvl || m_axis_tdata[26:19] !== e.occ) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp st=%0d id=%h lvl=%0d occ=%0d, ",
                                     e.st, e.id, e.lvl, e.occ,
                                     "got st=%0d id=%h lvl=%0d occ=%0d",
                                     m_axis_tuser, m_axis_tdata[15:0],
                                     m_axis_tdata[18:16], m_axis_tdata[26:19]);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule
